// File: hdl/assert_macros.svh
// assertion helpers included by largest_free_strip_finder.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/lfsf_pkg.sv
package lfsf_pkg;

  localparam int unsigned CoordBits           = 16;
  localparam int unsigned AreaBits            = 2 * CoordBits;
  localparam int unsigned MaxObstaclesDefault = 32;
  localparam int unsigned CfgIdxBits          = 8;

  typedef logic [CoordBits-1:0]  coord_t;
  typedef logic [AreaBits-1:0]   area_t;
  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t RegContLeft   = cfg_idx_t'(0);
  localparam cfg_idx_t RegContTop    = cfg_idx_t'(1);
  localparam cfg_idx_t RegContRight  = cfg_idx_t'(2);
  localparam cfg_idx_t RegContBottom = cfg_idx_t'(3);

  // one rectangle, x grows right and y grows down
  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef struct packed {
    coord_t obstacle_left;
    coord_t obstacle_top;
    coord_t obstacle_right;
    coord_t obstacle_bottom;
    logic   last;
  } in_t;

  typedef struct packed {
    coord_t best_left;
    coord_t best_top;
    coord_t best_right;
    coord_t best_bottom;
    area_t  best_area;
    logic   overflow;
  } out_t;

  // the four strips taken around one obstacle
  typedef enum logic [1:0] {
    STRIP_LEFT  = 2'd0,
    STRIP_RIGHT = 2'd1,
    STRIP_BELOW = 2'd2,
    STRIP_ABOVE = 2'd3
  } strip_e;

  // search sequencer
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_GET  = 9'b000000100,
    S_CAND = 9'b000001000,
    S_SCAN = 9'b000010000,
    S_AREA = 9'b000100000,
    S_CMP  = 9'b001000000,
    S_NEXT = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  // strict edge overlap
  function automatic logic boxes_overlap(box_t a, box_t b);
    return !((a.r <= b.l) || (a.l >= b.r) || (a.b <= b.t) || (a.t >= b.b));
  endfunction

  // inclusive containment
  function automatic logic box_inside(box_t in_box, box_t out_box);
    return (in_box.l >= out_box.l) && (in_box.r <= out_box.r) &&
           (in_box.t >= out_box.t) && (in_box.b <= out_box.b);
  endfunction

  // strip of the container on one side of an obstacle
  function automatic box_t build_strip(box_t cont, box_t obs, strip_e side);
    box_t s;
    s = cont;
    case (side)
      STRIP_LEFT:  s.r = obs.l;
      STRIP_RIGHT: s.l = obs.r;
      STRIP_BELOW: s.t = obs.b;
      STRIP_ABOVE: s.b = obs.t;
      default:     s = cont;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/largest_free_strip_finder.sv
// Obstacles are loaded one beat each and kept in load order in a small RAM; a beat that is
// not marked last leaves the block ready for the next beat. The beat marked last starts the
// search: each stored obstacle yields four strips of the container (left, right, below,
// above), each strip that lies inside the container is compared against the stored
// obstacles through the one RAM read port, one obstacle a cycle, until one overlaps it,
// and the largest strip with positive area wins, the earliest keeping a tie. No beat is
// taken during the search. The result waits in an output register while the next set
// loads. Obstacles beyond MAX_OBSTACLES are dropped and flagged in the result. The user
// must write container edges through the configuration port only while the block is
// idle; the block itself does not enforce this.
`include "assert_macros.svh"

module largest_free_strip_finder #(
  parameter int unsigned MAX_OBSTACLES = lfsf_pkg::MaxObstaclesDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  lfsf_pkg::in_t                          in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output lfsf_pkg::out_t                         out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lfsf_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [lfsf_pkg::CoordBits-1:0]         cfg_data_i
);

  import lfsf_pkg::*;

  localparam int unsigned AddrBits  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CountBits = $clog2(MAX_OBSTACLES + 1);
  localparam logic [CountBits-1:0] CountMax = CountBits'(MAX_OBSTACLES);

  state_e                 state_q, state_d;
  logic [CountBits-1:0]   count_q;
  logic                   ovf_q;
  logic [CountBits-1:0]   i_q;
  logic [CountBits-1:0]   k_q;
  strip_e                 j_q;
  logic                   pend_q;
  box_t                   cont_q;
  box_t                   obs_q;
  box_t                   cand_q;
  box_t                   cand_d;
  area_t                  area_q;
  area_t                  best_area_q;
  box_t                   best_rect_q;
  logic                   out_valid_q;
  out_t                   out_q;

  logic                   in_fire;
  logic                   cfg_fire;
  logic                   out_free;
  logic                   hit;
  logic                   scan_last;
  logic                   ram_we;
  logic [AddrBits-1:0]    ram_waddr;
  logic [AddrBits-1:0]    ram_raddr;
  box_t                   ram_wdata;
  box_t                   ram_rdata;

  // handshakes
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // obstacle store
  assign ram_we      = in_fire && (count_q < CountMax);
  assign ram_waddr   = count_q[AddrBits-1:0];
  assign ram_wdata   = '{l: in_data_i.obstacle_left,  t: in_data_i.obstacle_top,
                         r: in_data_i.obstacle_right, b: in_data_i.obstacle_bottom};
  assign ram_raddr   = (state_q == S_SCAN) ? k_q[AddrBits-1:0] : i_q[AddrBits-1:0];

  lfsf_ram #(
    .WIDTH ($bits(box_t)),
    .DEPTH (MAX_OBSTACLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare unit: candidate strip against the obstacle just read
  assign cand_d    = build_strip(cont_q, obs_q, j_q);
  assign hit       = pend_q && boxes_overlap(cand_q, ram_rdata);
  assign scan_last = (k_q == count_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_data_i.last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: state_d = S_GET;
      S_GET:  state_d = S_CAND;
      S_CAND: begin
        state_d = box_inside(cand_d, cont_q) ? S_SCAN : S_NEXT;
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_NEXT;
        end else if (scan_last) begin
          state_d = S_AREA;
        end
      end
      S_AREA: state_d = S_CMP;
      S_CMP:  state_d = S_NEXT;
      S_NEXT: begin
        if (j_q != STRIP_ABOVE) begin
          state_d = S_CAND;
        end else if (i_q == count_q - 1'b1) begin
          state_d = S_DONE;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      j_q         <= STRIP_LEFT;
      pend_q      <= 1'b0;
      cont_q      <= '0;
      best_area_q <= '0;
      best_rect_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // container edges
      if (cfg_fire) begin
        case (cfg_index_i)
          RegContLeft:   cont_q.l <= cfg_data_i;
          RegContTop:    cont_q.t <= cfg_data_i;
          RegContRight:  cont_q.r <= cfg_data_i;
          RegContBottom: cont_q.b <= cfg_data_i;
          default:       ;
        endcase
      end

      // result register: a new result replaces one leaving in the same cycle
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (count_q < CountMax) begin
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.last) begin
              i_q         <= '0;
              best_area_q <= '0;
              best_rect_q <= '0;
            end
          end
        end
        S_GET: j_q <= STRIP_LEFT;
        S_CAND: begin
          k_q    <= '0;
          pend_q <= 1'b0;
        end
        S_SCAN: begin
          if (!hit && !scan_last) begin
            k_q    <= k_q + 1'b1;
            pend_q <= 1'b1;
          end
        end
        S_CMP: begin
          if (area_q > best_area_q) begin
            best_area_q <= area_q;
            best_rect_q <= cand_q;
          end
        end
        S_NEXT: begin
          if (j_q == STRIP_ABOVE) begin
            j_q <= STRIP_LEFT;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= strip_e'(j_q + 1'b1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_GET:  obs_q  <= ram_rdata;
      S_CAND: cand_q <= cand_d;
      S_AREA: begin
        if ((cand_q.r > cand_q.l) && (cand_q.b > cand_q.t)) begin
          area_q <= AreaBits'(cand_q.r - cand_q.l) * AreaBits'(cand_q.b - cand_q.t);
        end else begin
          area_q <= '0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q <= '{best_left:   best_rect_q.l,
                     best_top:    best_rect_q.t,
                     best_right:  best_rect_q.r,
                     best_bottom: best_rect_q.b,
                     best_area:   best_area_q,
                     overflow:    ovf_q};
        end
      end
      default: ;
    endcase
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CountMax)
  `ASSERT_ALWAYS(a_ovf_when_full, clk_i, rst_ni, !ovf_q || count_q == CountMax)
  `ASSERT_ALWAYS(a_scan_bound, clk_i, rst_ni, state_q != S_SCAN || k_q <= count_q)
  `ASSERT_ALWAYS(a_best_positive, clk_i, rst_ni, best_area_q == '0 || (best_rect_q.r > best_rect_q.l && best_rect_q.b > best_rect_q.t))
  `ASSERT_NEXT(a_done_clears, clk_i, rst_ni, state_q == S_DONE && out_free, count_q == '0 && out_valid_q && state_q == S_IDLE)

endmodule

// File: hdl/lfsf_ram.sv
module lfsf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
